@@ design/fcv_pkg.sv @@
package fcv_pkg;

  // Trig unit
  localparam int TRIG_ITERATIONS = 14;
  localparam int ATAN_ENTRIES    = 24;
  localparam int CORDIC_STEPS    = (TRIG_ITERATIONS < ATAN_ENTRIES) ?
                                   TRIG_ITERATIONS : ATAN_ENTRIES;
  localparam int STEP_W          = $clog2(CORDIC_STEPS);
  localparam int TRIG_W          = 33;
  localparam int Z_W             = 26;
  localparam int ANG_W           = 15;
  localparam int ATAN_IDX_W      = 5;
  localparam logic signed [TRIG_W-1:0] CORDIC_START = 33'sd652032874;

  // Angles in Q.7 degrees
  localparam int FULL_TURN    = 46080;
  localparam int HALF_TURN    = 23040;
  localparam int QUARTER_TURN = 11520;
  localparam int PITCH_LIMIT  = 11392;

  // Event codes
  localparam logic [2:0] MODE_ROTATE   = 3'd0;
  localparam logic [2:0] MODE_FORWARD  = 3'd1;
  localparam logic [2:0] MODE_BACKWARD = 3'd2;
  localparam logic [2:0] MODE_LEFT     = 3'd3;
  localparam logic [2:0] MODE_RIGHT    = 3'd4;
  localparam logic [2:0] MODE_UP       = 3'd5;
  localparam logic [2:0] MODE_DOWN     = 3'd6;
  localparam logic [2:0] MODE_LOAD     = 3'd7;

  // Register indexes
  localparam logic [2:0] CFG_START_X     = 3'd0;
  localparam logic [2:0] CFG_START_Y     = 3'd1;
  localparam logic [2:0] CFG_START_Z     = 3'd2;
  localparam logic [2:0] CFG_START_YAW   = 3'd3;
  localparam logic [2:0] CFG_START_PITCH = 3'd4;

  // Port widths
  localparam int IN_W       = 40;
  localparam int USER_W     = 3;
  localparam int OUT_W      = 240;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // arctan(2^-i) in degrees, Q.16
  function automatic logic signed [Z_W-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ design/fcv_cordic.sv @@
module fcv_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [fcv_pkg::ANG_W-1:0]  angle,
  output logic                              done,
  output logic signed [31:0]                cos_q30,
  output logic signed [31:0]                sin_q30
);
  import fcv_pkg::*;

  logic signed [TRIG_W-1:0] x, y, dx, dy;
  logic signed [Z_W-1:0]    z, at;
  logic [STEP_W-1:0]        step;
  logic                     busy;

  always_comb begin
    dx = y >>> step;
    dy = x >>> step;
    at = atan_deg(ATAN_IDX_W'(step));
  end

  // One rotation step a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x    <= CORDIC_START;
        y    <= '0;
        z    <= Z_W'(signed'({angle, 9'b0}));
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        step <= step + 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign cos_q30 = x[31:0];
  assign sin_q30 = y[31:0];

endmodule

@@ design/fcv_mul.sv @@
module fcv_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);
  import fcv_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

@@ design/fly_camera_view_update.sv @@
// Fly camera view update.
// Slave channel: one beat per camera event; s_tuser carries the event kind
// (rotate, six moves, load start pose), s_tdata the mouse deltas and step.
// Master channel: one beat per event with the 3x3 look-at rotation rows in
// Q2.14 and the three translations in Q16.16.
// Config port: cfg_wr_en/cfg_addr/cfg_wdata writes the start pose registers;
// write only while the block is idle.
// A sequencer drives one shared CORDIC (one step a cycle, 14 steps) and
// one 32x32 multiplier. Rotate and load update yaw and pitch, wrap yaw, run
// the yaw and pitch trig passes, build the axes and form the dot products;
// moves run the trig and axis passes twice, moving the position in between.
// s_tready is high only in idle, so one event is in flight at a time.
// When the receiver stalls, the result beat holds on m_tdata and no new
// event is taken until it goes. Reset clears position, yaw, pitch and the
// start registers to zero and leaves the block idle.
module fly_camera_view_update (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [fcv_pkg::IN_W-1:0]          s_tdata,   // mouse_dx, mouse_dy, step_time
  input  logic [fcv_pkg::USER_W-1:0]        s_tuser,   // mode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // side_x/y/z, upward_x/y/z, back_x/y/z, shift_side, shift_up, shift_back
  output logic [fcv_pkg::OUT_W-1:0]         m_tdata,
  input  logic                              cfg_wr_en,
  input  logic [fcv_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [fcv_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import fcv_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_UPDATE, S_WRAP, S_TY_GO, S_TY, S_TP_GO, S_TP,
    S_AXMUL, S_MOVE, S_DOT, S_OUT
  } state_t;

  state_t state;

  logic signed [31:0] start_x, start_y, start_z;
  logic [15:0]        start_yaw;
  logic signed [14:0] start_pitch;

  logic signed [31:0] pos [3];
  logic [15:0]        yaw;
  logic signed [14:0] pitch;
  logic signed [19:0] yaw_w;

  logic [2:0]         mode;
  logic signed [11:0] mdx, mdy;
  logic [15:0]        dt;
  logic               second, flip, neg;

  logic signed [31:0] cy, sy, cp, sp;
  logic signed [15:0] vec [9];
  logic signed [31:0] shift_r [3];
  logic signed [48:0] acc;
  logic [1:0]         k, rowi, col;
  logic               ph;

  // Trig unit and multiplier
  logic               tr_start, tr_done;
  logic signed [ANG_W-1:0] tr_angle;
  logic signed [31:0] tr_c, tr_s;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;

  fcv_cordic u_cordic (
    .clk(clk), .rst(rst), .start(tr_start), .angle(tr_angle),
    .done(tr_done), .cos_q30(tr_c), .sin_q30(tr_s)
  );

  fcv_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  function automatic logic signed [15:0] to14(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + 64'sd32768) >>> 16;
    if (t > 64'sd16384) t = 64'sd16384;
    else if (t < -64'sd16384) t = -64'sd16384;
    return 16'(t);
  endfunction

  function automatic logic signed [63:0] mulq30(input logic signed [63:0] p);
    return (p + 64'sd536870912) >>> 30;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

  function automatic logic signed [14:0] clamp_pitch(input logic signed [20:0] v);
    logic signed [14:0] r;
    if (v > 21'(PITCH_LIMIT)) r = 15'(PITCH_LIMIT);
    else if (v < -21'(PITCH_LIMIT)) r = -15'(PITCH_LIMIT);
    else r = 15'(v);
    return r;
  endfunction

  // Fold yaw into plus or minus a quarter turn, noting a half-turn flip
  logic signed [17:0] ya;
  logic               flip_c;
  always_comb begin
    ya = 18'(signed'({2'b0, yaw}));
    flip_c = 1'b0;
    if (ya >= 18'(HALF_TURN)) ya = ya - 18'(FULL_TURN);
    if (ya > 18'(QUARTER_TURN)) begin
      ya = ya - 18'(HALF_TURN);
      flip_c = 1'b1;
    end else if (ya < -18'(QUARTER_TURN)) begin
      ya = ya + 18'(HALF_TURN);
      flip_c = 1'b1;
    end
  end

  assign tr_start = (state == S_TY_GO) || (state == S_TP_GO);
  assign tr_angle = (state == S_TY_GO) ? ANG_W'(ya) : pitch;

  logic [3:0] vidx;
  assign vidx = 4'({rowi, 1'b0}) + 4'(rowi) + 4'(col);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_AXMUL: begin
        case (k)
          2'd0: begin mul_a = cy; mul_b = sp; end
          2'd1: begin mul_a = sy; mul_b = sp; end
          2'd2: begin mul_a = cy; mul_b = cp; end
          default: begin mul_a = sy; mul_b = cp; end
        endcase
      end
      S_MOVE: begin
        mul_a = 32'(vec[vidx]);
        mul_b = 32'(signed'({16'b0, dt}));
      end
      S_DOT: begin
        mul_a = 32'(vec[vidx]);
        mul_b = pos[col];
      end
      default: ;
    endcase
  end

  // Datapath values for the current multiply step
  logic signed [63:0] mv_p, mv_d;
  logic signed [48:0] dot_tot;
  logic signed [49:0] dot_r;
  always_comb begin
    mv_p    = neg ? -mul_p : mul_p;
    mv_d    = (mv_p + 64'sd512) >>> 10;
    dot_tot = acc + 49'(mul_p);
    dot_r   = (-50'(dot_tot) + 50'sd8192) >>> 14;
  end

  // Start pose registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x     <= '0;
      start_y     <= '0;
      start_z     <= '0;
      start_yaw   <= '0;
      start_pitch <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_START_X:     start_x     <= cfg_wdata;
        CFG_START_Y:     start_y     <= cfg_wdata;
        CFG_START_Z:     start_z     <= cfg_wdata;
        CFG_START_YAW:   start_yaw   <= cfg_wdata[15:0];
        CFG_START_PITCH: start_pitch <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      pos[0]   <= '0;
      pos[1]   <= '0;
      pos[2]   <= '0;
      yaw      <= '0;
      pitch    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            mode <= s_tuser;
            mdx  <= s_tdata[11:0];
            mdy  <= s_tdata[23:12];
            dt   <= s_tdata[39:24];
            case (s_tuser) inside
              MODE_ROTATE, MODE_LOAD: state <= S_UPDATE;
              default: begin
                second <= 1'b0;
                state  <= S_TY_GO;
              end
            endcase
          end
        end
        S_UPDATE: begin
          if (mode == MODE_ROTATE) begin
            yaw_w <= 20'(signed'({4'b0, yaw})) + 20'(signed'({mdx, 7'b0}));
            pitch <= clamp_pitch(21'(pitch) - 21'(signed'({mdy, 7'b0})));
          end else begin
            pos[0] <= start_x;
            pos[1] <= start_y;
            pos[2] <= start_z;
            yaw_w  <= 20'(signed'({4'b0, start_yaw}));
            pitch  <= clamp_pitch(21'(start_pitch));
          end
          state <= S_WRAP;
        end
        S_WRAP: begin
          // Step yaw by whole turns until it lands in [0, 360) degrees
          if (yaw_w < 0) yaw_w <= yaw_w + 20'(FULL_TURN);
          else if (yaw_w >= 20'(FULL_TURN)) yaw_w <= yaw_w - 20'(FULL_TURN);
          else begin
            yaw    <= 16'(yaw_w);
            second <= 1'b1;
            state  <= S_TY_GO;
          end
        end
        S_TY_GO: begin
          flip  <= flip_c;
          state <= S_TY;
        end
        S_TY: begin
          if (tr_done) begin
            cy    <= flip ? -tr_c : tr_c;
            sy    <= flip ? -tr_s : tr_s;
            state <= S_TP_GO;
          end
        end
        S_TP_GO: state <= S_TP;
        S_TP: begin
          if (tr_done) begin
            cp     <= tr_c;
            sp     <= tr_s;
            vec[0] <= to14(-64'(sy));
            vec[1] <= '0;
            vec[2] <= to14(64'(cy));
            vec[4] <= to14(64'(tr_c));
            vec[7] <= to14(-64'(tr_s));
            k      <= '0;
            ph     <= 1'b0;
            state  <= S_AXMUL;
          end
        end
        S_AXMUL: begin
          ph <= ~ph;
          if (ph) begin
            case (k)
              2'd0: vec[3] <= to14(-mulq30(mul_p));
              2'd1: vec[5] <= to14(-mulq30(mul_p));
              2'd2: vec[6] <= to14(-mulq30(mul_p));
              default: vec[8] <= to14(-mulq30(mul_p));
            endcase
            k <= k + 1'b1;
            if (k == 2'd3) begin
              col <= '0;
              acc <= '0;
              if (second) begin
                rowi  <= '0;
                state <= S_DOT;
              end else begin
                case (mode) inside
                  MODE_FORWARD, MODE_BACKWARD: rowi <= 2'd2;
                  MODE_LEFT, MODE_RIGHT:       rowi <= 2'd0;
                  default:                     rowi <= 2'd1;
                endcase
                neg <= (mode == MODE_FORWARD) || (mode == MODE_LEFT) ||
                       (mode == MODE_DOWN);
                state <= S_MOVE;
              end
            end
          end
        end
        S_MOVE: begin
          ph <= ~ph;
          if (ph) begin
            pos[col] <= sat32(66'(pos[col]) + 66'(mv_d));
            col      <= col + 1'b1;
            if (col == 2'd2) begin
              second <= 1'b1;
              state  <= S_TY_GO;
            end
          end
        end
        S_DOT: begin
          ph <= ~ph;
          if (ph) begin
            if (col == 2'd2) begin
              shift_r[rowi] <= sat32(66'(dot_r));
              acc  <= '0;
              col  <= '0;
              rowi <= rowi + 1'b1;
              if (rowi == 2'd2) begin
                m_tvalid <= 1'b1;
                state    <= S_OUT;
              end
            end else begin
              acc <= dot_tot;
              col <= col + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {shift_r[2], shift_r[1], shift_r[0],
                     vec[8], vec[7], vec[6], vec[5], vec[4],
                     vec[3], vec[2], vec[1], vec[0]};

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken while result pending");
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    (pitch <= 15'(PITCH_LIMIT)) && (pitch >= -15'(PITCH_LIMIT)))
    else $error("pitch beyond limit");
  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    (yaw < 16'(FULL_TURN))) else $error("yaw not wrapped");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed");
`endif

endmodule
